// ----- rtl/core/oled_gw_pkg.sv -----
// Shared types, constants and the glyph table for the OLED glyph writer.
package oled_gw_pkg;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Byte sequence started by a request
  typedef enum logic [1:0] {
    K_CHAR,
    K_CURSOR,
    K_CURSOR_UL,
    K_WRAP
  } kind_t;

  // Configuration register indexes
  localparam logic [1:0] REG_WRAP_ENABLE       = 2'd0;
  localparam logic [1:0] REG_CURSOR_ENABLE     = 2'd1;
  localparam logic [1:0] REG_COLUMN_OFFSET     = 2'd2;
  localparam logic [1:0] REG_PAGE_COMMAND_BASE = 2'd3;

  // Request types
  localparam logic REQ_CHAR   = 1'b0;
  localparam logic REQ_CURSOR = 1'b1;

  // Character handling
  localparam logic [7:0] NEWLINE_CODE    = 8'd10;
  localparam logic [7:0] MAX_COLUMN      = 8'd120;
  localparam logic [7:0] CTRL_CODE_LIMIT = 8'd9;
  localparam logic [7:0] CTRL_GLYPH_BASE = 8'd94;
  localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
  localparam logic [7:0] GLYPH_ADVANCE   = 8'd8;

  // Command and cursor bytes
  localparam logic [3:0] CMD_COL_HIGH = 4'h1;
  localparam logic [3:0] CMD_COL_LOW  = 4'h0;
  localparam logic [7:0] CURSOR_ERASE = 8'h00;
  localparam logic [7:0] CURSOR_BAR   = 8'hf0;

  // Step numbers inside each sequence
  localparam logic [4:0] CHAR_ADDR1   = 5'd8;
  localparam logic [4:0] CHAR_HIGH    = 5'd11;
  localparam logic [4:0] CHAR_ADDR2   = 5'd19;
  localparam logic [4:0] CHAR_LAST    = 5'd21;
  localparam logic [4:0] UL_BAR       = 5'd4;
  localparam logic [4:0] UL_LAST      = 5'd7;
  localparam logic [4:0] ADDR_LAST    = 5'd2;

  // Font ROM geometry
  localparam int GLYPH_COUNT = 102;
  localparam int GLYPH_IDX_W = 7;
  localparam int GLYPH_BITS  = 64;

  // Font ROM read port
  typedef struct packed {
    logic       en;
    logic [7:0] idx;
  } rom_req_t;

  // Double every bit of a nibble
  function automatic logic [7:0] dbl_nibble(input logic [3:0] nib);
    dbl_nibble = {nib[3], nib[3], nib[2], nib[2], nib[1], nib[1], nib[0], nib[0]};
  endfunction

  // One word per glyph, column 0 in the top byte
  localparam logic [GLYPH_BITS-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
    64'h0000000000000000, 64'h0000004f4f000000, 64'h0007070000070700,
    64'h147f7f14147f7f14, 64'h00242e6b6b3a1200, 64'h006333180c666300,
    64'h00327f4d4d777250, 64'h0000000406030100, 64'h00001c3e63410000,
    64'h000041633e1c0000, 64'h082a3e1c1c3e2a08, 64'h0008083e3e080800,
    64'h000080e060000000, 64'h0008080808080800, 64'h0000006060000000,
    64'h00406030180c0602, 64'h003e7f49457f3e00, 64'h0040447f7f404000,
    64'h00627351494f4600, 64'h00226349497f3600, 64'h00181814167f7f10,
    64'h00276745457d3900, 64'h003e7f49497b3200, 64'h000303797d070300,
    64'h00367f49497f3600, 64'h00266f49497f3e00, 64'h0000002424000000,
    64'h000080e464000000, 64'h00081c3663414100, 64'h0014141414141400,
    64'h00414163361c0800, 64'h00020351590f0600, 64'h003e7f414d4f2e00,
    64'h007c7e0b0b7e7c00, 64'h007f7f49497f3600, 64'h003e7f4141632200,
    64'h007f7f41633e1c00, 64'h007f7f4949414100, 64'h007f7f0909010100,
    64'h003e7f41497b3a00, 64'h007f7f08087f7f00, 64'h0000417f7f410000,
    64'h002060417f3f0100, 64'h007f7f1c36634100, 64'h007f7f4040404000,
    64'h007f7f060c067f7f, 64'h007f7f0e1c7f7f00, 64'h003e7f41417f3e00,
    64'h007f7f09090f0600, 64'h001e3f21617f5e00, 64'h007f7f19396f4600,
    64'h00266f49497b3200, 64'h0001017f7f010100, 64'h003f7f40407f3f00,
    64'h001f3f60603f1f00, 64'h007f7f3018307f7f, 64'h0063771c1c776300,
    64'h00070f78780f0700, 64'h006171594d474300, 64'h00007f7f41410000,
    64'h0002060c18306040, 64'h000041417f7f0000, 64'h00080cfefe0c0800,
    64'h8080808080808080, 64'h0001030604000000, 64'h00207454547c7800,
    64'h007e7e4848783000, 64'h00387c4444440000, 64'h00307848487e7e00,
    64'h00387c54545c1800, 64'h0000087c7e0a0a00, 64'h0098bca4a4fc7c00,
    64'h007e7e0808787000, 64'h0000487a7a400000, 64'h0000808080fa7a00,
    64'h007e7e1038684000, 64'h0000427e7e400000, 64'h007c7c18381c7c78,
    64'h007c7c04047c7800, 64'h00387c44447c3800, 64'h00fcfc24243c1800,
    64'h00183c2424fcfc00, 64'h007c7c04040c0800, 64'h00485c5454742400,
    64'h0004043e7e444400, 64'h003c7c40407c7c00, 64'h001c3c60603c1c00,
    64'h001c7c7038707c1c, 64'h00446c38386c4400, 64'h009cbca0e07c3c00,
    64'h004464745c4c4400, 64'h00083e7741410000, 64'h000000ffff000000,
    64'h00004141773e0800, 64'h0004020204040200, 64'h00552a2a14140808,
    64'h0000000000000000, 64'h0000001f00000000, 64'h0000001f001f0000,
    64'h0000001f001f001f, 64'h001c1e05051e1c00, 64'h001f1f15150a0a00
  };

endpackage

// ----- rtl/core/oled_gw_ifs.sv -----
// Handshake channels: text requests in, controller bytes out.
interface oled_gw_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_code;
  logic [3:0] text_col;
  logic       text_row;

  modport source (output valid, req_type, char_code, text_col, text_row, input ready);
  modport sink   (input valid, req_type, char_code, text_col, text_row, output ready);
endinterface

interface oled_gw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last;

  modport source (output valid, out_byte, is_data, last, input ready);
  modport sink   (input valid, out_byte, is_data, last, output ready);
endinterface

// ----- rtl/core/oled_text_glyph_writer_unit.sv -----
// A taken request sets the state register to run, which then loads the first byte into the
// output register; after that one byte per cycle while the output is not stalled. A character
// sends 22 bytes, a cursor move 3 (8 with underline), a wrap 3 and a dropped request none.
// The font ROM is read once per character at request time; the word is held for all columns.
// Reset (rst, synchronous): column and page to 0, registers to defaults, output empty.
module oled_text_glyph_writer_unit
  import oled_gw_pkg::*;
#(
  parameter int DISPLAY_PAGES = 4
) (
  input  logic              clk,
  input  logic              rst,
  oled_gw_req_if.sink       request,
  oled_gw_byte_if.source    stream,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  localparam logic [3:0] PAGE_LIMIT = 4'(DISPLAY_PAGES - 2);

  state_t                state, state_next;
  kind_t                 kind, acc_kind;
  logic [4:0]            step;
  logic [7:0]            new_col;
  logic [2:0]            new_page;
  logic [7:0]            pixel_column;
  logic [2:0]            page_index;
  logic                  wrap_enable, cursor_enable;
  logic [1:0]            column_offset;
  logic [7:0]            page_command_base;
  logic                  ovalid, odata, olast;
  logic [7:0]            obyte;
  logic                  accept, acc_go, drop_char, adv;
  logic [7:0]            glyph_idx;
  rom_req_t              rom_rd;
  logic [GLYPH_BITS-1:0] glyph;

  // Sequencer decode outputs
  logic       seq_addr, seq_hi, seq_last, seq_wr;
  logic [1:0] seq_pos;
  logic [2:0] seq_ci;
  logic [7:0] seq_const, seq_byte;
  logic       seq_const_sel;
  logic [7:0] cand_col, shifted, glyph_col;
  logic [2:0] cand_page;
  logic [4:0] rel;
  logic [3:0] wrap_page;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_enable       <= 1'b1;
      cursor_enable     <= 1'b0;
      column_offset     <= 2'd0;
      page_command_base <= 8'd176;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WRAP_ENABLE:       wrap_enable       <= cfg_data[0];
        REG_CURSOR_ENABLE:     cursor_enable     <= cfg_data[0];
        REG_COLUMN_OFFSET:     column_offset     <= cfg_data[1:0];
        REG_PAGE_COMMAND_BASE: page_command_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request decode
  assign request.ready = (state == ST_IDLE);
  assign accept        = request.valid && request.ready;
  assign drop_char     = (request.char_code == NEWLINE_CODE) || (pixel_column > MAX_COLUMN);
  assign glyph_idx     = (request.char_code < CTRL_CODE_LIMIT)
                         ? request.char_code + CTRL_GLYPH_BASE
                         : request.char_code - FIRST_PRINTABLE;

  always_comb begin
    acc_go   = 1'b1;
    acc_kind = K_CHAR;
    if (request.req_type == REQ_CURSOR) begin
      acc_kind = cursor_enable ? K_CURSOR_UL : K_CURSOR;
    end else if (drop_char) begin
      acc_kind = K_WRAP;
      acc_go   = wrap_enable;
    end
  end

  assign rom_rd.en  = accept && (request.req_type == REQ_CHAR);
  assign rom_rd.idx = glyph_idx;

  oled_gw_font_rom u_rom (
    .clk  (clk),
    .rd   (rom_rd),
    .data (glyph)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign adv = (state == ST_RUN) && (!ovalid || stream.ready);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && acc_go) state_next = ST_RUN;
      ST_RUN:  if (adv && seq_last)  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Request context and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      kind <= K_CHAR;
    end else if (accept) begin
      step <= '0;
      kind <= acc_kind;
    end else if (adv) begin
      step <= step + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      new_col  <= {request.text_col, 3'b000};
      new_page <= {1'b0, request.text_row, 1'b0};
    end
  end

  // Step decode: data bytes, cursor constant bytes, address triples and their target position
  assign wrap_page = ({1'b0, page_index} + 4'd2 > PAGE_LIMIT)
                     ? PAGE_LIMIT : {1'b0, page_index} + 4'd2;

  always_comb begin
    seq_addr      = 1'b0;
    seq_hi        = 1'b0;
    seq_ci        = step[2:0];
    seq_const_sel = 1'b0;
    seq_const     = CURSOR_ERASE;
    rel           = step;
    cand_col      = pixel_column;
    cand_page     = page_index;
    seq_last      = 1'b0;
    unique case (kind)
      K_CHAR: begin
        seq_last = (step == CHAR_LAST);
        if (step >= CHAR_ADDR2) begin
          seq_addr  = 1'b1;
          rel       = step - CHAR_ADDR2;
          cand_col  = pixel_column + GLYPH_ADVANCE;
          cand_page = page_index + 3'd7;
        end else if (step >= CHAR_HIGH) begin
          seq_hi = 1'b1;
          rel    = step - CHAR_HIGH;
          seq_ci = rel[2:0];
        end else if (step >= CHAR_ADDR1) begin
          seq_addr  = 1'b1;
          rel       = step - CHAR_ADDR1;
          cand_page = page_index + 3'd1;
        end
      end
      K_CURSOR_UL: begin
        seq_last = (step == UL_LAST);
        if (step == 5'd0) begin
          seq_const_sel = 1'b1;
        end else if (step == UL_BAR) begin
          seq_const_sel = 1'b1;
          seq_const     = CURSOR_BAR;
        end else if (step > UL_BAR) begin
          seq_addr = 1'b1;
          rel      = step - (UL_BAR + 5'd1);
        end else begin
          seq_addr  = 1'b1;
          rel       = step - 5'd1;
          cand_col  = new_col;
          cand_page = new_page;
        end
      end
      K_CURSOR: begin
        seq_last  = (step == ADDR_LAST);
        seq_addr  = 1'b1;
        cand_col  = new_col;
        cand_page = new_page;
      end
      K_WRAP: begin
        seq_last  = (step == ADDR_LAST);
        seq_addr  = 1'b1;
        cand_col  = '0;
        cand_page = wrap_page[2:0];
      end
      default: ;
    endcase
  end

  assign seq_pos   = rel[1:0];
  assign seq_wr    = seq_addr && (seq_pos == 2'd0);
  assign shifted   = pixel_column + {6'b0, column_offset};
  assign glyph_col = glyph[{~seq_ci, 3'b000} +: 8];

  // Byte mux
  always_comb begin
    if (seq_addr) begin
      unique case (seq_pos)
        2'd0:    seq_byte = page_command_base | {5'b0, cand_page};
        2'd1:    seq_byte = {CMD_COL_HIGH, shifted[7:4]};
        default: seq_byte = {CMD_COL_LOW, shifted[3:0]};
      endcase
    end else if (seq_const_sel) begin
      seq_byte = seq_const;
    end else begin
      seq_byte = dbl_nibble(seq_hi ? glyph_col[7:4] : glyph_col[3:0]);
    end
  end

  // Position update on the page byte of each address triple
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column <= '0;
      page_index   <= '0;
    end else if (adv && seq_wr) begin
      pixel_column <= cand_col;
      page_index   <= cand_page;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (adv) begin
      ovalid <= 1'b1;
    end else if (stream.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      obyte <= seq_byte;
      odata <= !seq_addr;
      olast <= seq_last;
    end
  end

  assign stream.valid    = ovalid;
  assign stream.out_byte = obyte;
  assign stream.is_data  = odata;
  assign stream.last     = olast;

  // Checks
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && kind != K_CHAR) |-> (step <= UL_LAST))
    else $error("step counter past end of sequence");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (adv && seq_last) |=> (state == ST_IDLE && stream.valid && stream.last))
    else $error("last byte did not close the request");

  a_page_cmd: assert property (@(posedge clk) disable iff (rst)
    (adv && seq_wr) |=> (stream.valid && !stream.is_data && !stream.last))
    else $error("page command marked as data or final");

endmodule

// ----- rtl/core/oled_gw_font_rom.sv -----
// Synchronous font ROM: one glyph word per read, registered output.
module oled_gw_font_rom
  import oled_gw_pkg::*;
(
  input  logic                  clk,
  input  rom_req_t              rd,
  output logic [GLYPH_BITS-1:0] data
);

  // Read on request; indexes past the table read as blank, data holds otherwise
  always_ff @(posedge clk) begin
    if (rd.en) begin
      if (rd.idx < 8'(GLYPH_COUNT)) begin
        data <= GLYPH_ROM[rd.idx[GLYPH_IDX_W-1:0]];
      end else begin
        data <= '0;
      end
    end
  end

endmodule
